FILE: rtl/core/prfb_pkg.sv
// Shared types and constants for the per-channel PReLU forward/backward engine.
package prfb_pkg;

    // Channel index width and the number of channels it can address
    localparam int CHAN_W    = 6;
    localparam int CHAN_SPAN = 2 ** CHAN_W;

    // Q8.8 saturation limits
    localparam logic signed [15:0] Q_MAX16 = 16'sh7FFF;
    localparam logic signed [15:0] Q_MIN16 = 16'sh8000;

    // Q32.16 accumulator saturation limits
    localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

    // Operation codes
    typedef enum logic [1:0] {
        FUNC_WRITE_SLOPE = 2'd0,
        FUNC_FORWARD     = 2'd1,
        FUNC_BACKWARD    = 2'd2,
        FUNC_READ_GRAD   = 2'd3
    } t_func;

    // Input word
    typedef struct packed {
        t_func                    func;
        logic [CHAN_W-1:0]        chan;
        logic signed [15:0]       sample;
        logic signed [15:0]       grad_in;
        logic signed [15:0]       slope_value;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic signed [15:0]       value_out;
        logic signed [47:0]       grad_sum;
        logic                     clipped;
    } t_out_word;

    // Word held between the multiply stage and the result stage
    typedef struct packed {
        t_func                    func;
        logic [CHAN_W-1:0]        chan;
        logic                     chan_ok;
        logic signed [15:0]       sample;
        logic signed [15:0]       grad_in;
        logic signed [31:0]       prod_v;
        logic signed [31:0]       prod_g;
        logic signed [47:0]       acc_rd;
    } t_mid_word;

    // Accumulator write port
    typedef struct packed {
        logic                     en;
        logic [CHAN_W-1:0]        chan;
        logic signed [47:0]       data;
    } t_acc_wr;

endpackage

FILE: rtl/core/prfb_slope_mem.sv
// Slope table: one write and one registered read per cycle, per-entry valid bits.
module prfb_slope_mem #(
    parameter int DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [prfb_pkg::CHAN_W-1:0]   i_chan,
    input  logic                          i_rd_en,
    input  logic                          i_wr_en,
    input  logic signed [15:0]            i_wr_data,
    output logic signed [15:0]            o_rd_data
);
    import prfb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [15:0] r_mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    logic signed [15:0] r_rd_data;
    logic               r_rd_vld;
    logic [AW-1:0]      addr;

    assign addr = i_chan[AW-1:0];

    // Storage and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[addr];
        end
    end

    // Valid bits: an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

FILE: rtl/core/prfb_acc_mem.sv
// Gradient accumulator store: one write and one registered read per cycle, valid bits.
module prfb_acc_mem #(
    parameter int DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [prfb_pkg::CHAN_W-1:0]   i_rd_chan,
    input  prfb_pkg::t_acc_wr             i_wr,
    output logic signed [47:0]            o_rd_data
);
    import prfb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [47:0] r_mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    logic signed [47:0] r_rd_data;
    logic               r_rd_vld;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;

    assign rd_addr = i_rd_chan[AW-1:0];
    assign wr_addr = i_wr.chan[AW-1:0];

    // Storage and registered read (old data on a same-address collision)
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[wr_addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Valid bits stand for the all-zero reset contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

FILE: rtl/core/prfb_mul_stage.sv
// Input register and multiply stage: slope and gradient products into the mid register.
module prfb_mul_stage #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  prfb_pkg::t_in_word       i_word,
    output logic                     o_in_ready,
    input  logic signed [15:0]       i_slope,
    input  logic signed [47:0]       i_acc,
    output logic                     o_mid_valid,
    output prfb_pkg::t_mid_word      o_mid,
    input  logic                     i_mid_ready
);
    import prfb_pkg::*;

    logic               r_a_v;
    t_in_word           r_a;
    logic               r_b_v;
    t_mid_word          r_b;
    t_mid_word          n_b;
    logic               en_a;
    logic               a_chan_ok;
    logic signed [15:0] slope_eff;
    logic signed [15:0] mul_op;

    assign en_a       = !r_a_v || i_mid_ready;
    assign o_in_ready = en_a;

    // Products for the word in the input register
    always_comb begin
        a_chan_ok = int'(r_a.chan) < DEPTH;
        slope_eff = a_chan_ok ? i_slope : '0;
        mul_op    = (r_a.func == FUNC_FORWARD) ? r_a.sample : r_a.grad_in;

        n_b.func    = r_a.func;
        n_b.chan    = r_a.chan;
        n_b.chan_ok = a_chan_ok;
        n_b.sample  = r_a.sample;
        n_b.grad_in = r_a.grad_in;
        n_b.prod_v  = slope_eff * mul_op;
        n_b.prod_g  = r_a.sample * r_a.grad_in;
        n_b.acc_rd  = i_acc;
    end

    // Stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_v <= i_valid;
            end
            if (i_mid_ready) begin
                r_b_v <= r_a_v;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a <= i_word;
        end
        if (i_mid_ready) begin
            r_b <= n_b;
        end
    end

    assign o_mid_valid = r_b_v;
    assign o_mid       = r_b;

endmodule

FILE: rtl/core/prfb_result_stage.sv
// Result stage: Q8.8 clamp, accumulator update with forwarding, output register.
module prfb_result_stage (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_mid_valid,
    input  prfb_pkg::t_mid_word      i_mid,
    output logic                     o_mid_ready,
    output prfb_pkg::t_acc_wr        o_acc_wr,
    output logic                     o_valid,
    input  logic                     i_stall,
    output prfb_pkg::t_out_word      o_word
);
    import prfb_pkg::*;

    logic               r_out_v;
    t_out_word          r_out;
    t_out_word          n_out;
    t_acc_wr            r_h0;
    t_acc_wr            r_h1;
    t_acc_wr            acc_wr;
    logic               en_out;
    logic               advance;
    logic               x_neg;
    logic signed [23:0] v_sh;
    logic signed [15:0] v_clamp;
    logic               v_sat;
    logic signed [47:0] acc_cur;
    logic signed [48:0] acc_sum;
    logic signed [47:0] acc_sat_val;
    logic               acc_sat;

    assign en_out      = !r_out_v || !i_stall;
    assign o_mid_ready = !i_mid_valid || en_out;
    assign advance     = i_mid_valid && en_out;
    assign x_neg       = i_mid.sample[15];

    // Truncate the slope product to Q8.8 and saturate
    always_comb begin
        v_sh = 24'(i_mid.prod_v >>> 8);
        priority if (v_sh > 24'(Q_MAX16)) begin
            v_clamp = Q_MAX16;
            v_sat   = 1'b1;
        end else if (v_sh < 24'(Q_MIN16)) begin
            v_clamp = Q_MIN16;
            v_sat   = 1'b1;
        end else begin
            v_clamp = v_sh[15:0];
            v_sat   = 1'b0;
        end
    end

    // Current accumulator: the two most recent writes override the stored read
    always_comb begin
        priority if (r_h0.en && r_h0.chan == i_mid.chan) begin
            acc_cur = r_h0.data;
        end else if (r_h1.en && r_h1.chan == i_mid.chan) begin
            acc_cur = r_h1.data;
        end else begin
            acc_cur = i_mid.acc_rd;
        end
    end

    // Accumulate x*dy with 48-bit saturation
    always_comb begin
        acc_sum = 49'(acc_cur) + 49'(i_mid.prod_g);
        priority if (!acc_sum[48] && acc_sum[47]) begin
            acc_sat_val = ACC_MAX;
            acc_sat     = 1'b1;
        end else if (acc_sum[48] && !acc_sum[47]) begin
            acc_sat_val = ACC_MIN;
            acc_sat     = 1'b1;
        end else begin
            acc_sat_val = acc_sum[47:0];
            acc_sat     = 1'b0;
        end
    end

    // Result word and accumulator write per operation
    always_comb begin
        n_out       = '0;
        acc_wr.en   = 1'b0;
        acc_wr.chan = i_mid.chan;
        acc_wr.data = '0;
        unique case (i_mid.func)
            FUNC_WRITE_SLOPE: begin
                n_out = '0;
            end
            FUNC_FORWARD: begin
                n_out.value_out = x_neg ? v_clamp : i_mid.sample;
                n_out.clipped   = x_neg && v_sat;
            end
            FUNC_BACKWARD: begin
                n_out.value_out = x_neg ? v_clamp : i_mid.grad_in;
                n_out.clipped   = x_neg && (v_sat || (i_mid.chan_ok && acc_sat));
                acc_wr.en       = advance && x_neg && i_mid.chan_ok;
                acc_wr.data     = acc_sat_val;
            end
            FUNC_READ_GRAD: begin
                n_out.grad_sum = i_mid.chan_ok ? acc_cur : '0;
                acc_wr.en      = advance && i_mid.chan_ok;
                acc_wr.data    = '0;
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    assign o_acc_wr = acc_wr;

    // Output valid and write history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_h0    <= '0;
            r_h1    <= '0;
        end else begin
            if (en_out) begin
                r_out_v <= i_mid_valid;
            end
            if (acc_wr.en) begin
                r_h0 <= acc_wr;
                r_h1 <= r_h0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_word  = r_out;

`ifndef ASSERT_OFF
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_v)
        else $error("output valid not cleared by reset");

    a_wr_only_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_wr.en |-> (i_mid_valid && en_out && i_mid.chan_ok))
        else $error("accumulator written without the mid word advancing");

    a_history_tracks_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_wr.en |=> (r_h0.en && r_h0.chan == $past(acc_wr.chan)
                       && r_h0.data == $past(acc_wr.data)))
        else $error("write history missed an accumulator write");

    a_readout_word_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.grad_sum != '0) |-> (r_out.value_out == '0 && !r_out.clipped))
        else $error("readout word carries a value or clip flag");
`endif

endmodule

FILE: rtl/core/prelu_forward_backward.sv
// Top level of the per-channel PReLU forward/backward engine.
//
// Input channel: i_valid / o_stall carry one word per op (write slope,
// forward, backward, read-and-clear gradient) on i_word. A word is taken at
// a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry exactly one result word per input
// word, in order, on o_word.
// Pipeline: a word passes three registers in order (input register with the
// table reads, multiply register, result register) before o_valid rises.
// Throughput: one word per cycle unless i_stall holds a full output register;
// slope reads, accumulator read-modify-write and forwarding of the two most
// recent accumulator writes all keep pace. Stall: when i_stall holds a full
// output register, the stages fill behind it and o_stall rises only once
// every stage holds a word; empty stages keep accepting.
// Reset (synchronous, active low): clears all stage valid flags and the
// per-entry valid bits of the slope table and the accumulators, so every
// slope and accumulator reads as zero; no clearing pass.
module prelu_forward_backward #(
    parameter int CHANNELS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  prfb_pkg::t_in_word    i_word,
    output logic                  o_valid,
    input  logic                  i_stall,
    output prfb_pkg::t_out_word   o_word
);
    import prfb_pkg::*;

    localparam int DEPTH = (CHANNELS < CHAN_SPAN) ? CHANNELS : CHAN_SPAN;

    logic               in_ready;
    logic               in_accept;
    logic               in_chan_ok;
    logic               slope_wr_en;
    logic signed [15:0] slope_rd;
    logic signed [47:0] acc_rd;
    t_acc_wr            acc_wr;
    logic               mid_valid;
    t_mid_word          mid;
    logic               mid_ready;

    assign in_accept   = i_valid && in_ready;
    assign in_chan_ok  = int'(i_word.chan) < DEPTH;
    assign slope_wr_en = in_accept && (i_word.func == FUNC_WRITE_SLOPE) && in_chan_ok;
    assign o_stall     = !in_ready;

    // Slope table, written as the word is taken
    prfb_slope_mem #(
        .DEPTH (DEPTH)
    ) u_slope_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_chan    (i_word.chan),
        .i_rd_en   (in_accept),
        .i_wr_en   (slope_wr_en),
        .i_wr_data (i_word.slope_value),
        .o_rd_data (slope_rd)
    );

    // Gradient accumulators
    prfb_acc_mem #(
        .DEPTH (DEPTH)
    ) u_acc_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept),
        .i_rd_chan (i_word.chan),
        .i_wr      (acc_wr),
        .o_rd_data (acc_rd)
    );

    // Input register and products
    prfb_mul_stage #(
        .DEPTH (DEPTH)
    ) u_mul_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_word      (i_word),
        .o_in_ready  (in_ready),
        .i_slope     (slope_rd),
        .i_acc       (acc_rd),
        .o_mid_valid (mid_valid),
        .o_mid       (mid),
        .i_mid_ready (mid_ready)
    );

    // Clamp, accumulate and output register
    prfb_result_stage u_result_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (mid_valid),
        .i_mid       (mid),
        .o_mid_ready (mid_ready),
        .o_acc_wr    (acc_wr),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_word      (o_word)
    );

endmodule
